// ===== hdl/trle_pkg.sv =====
// ============================================================================
// Transparent-run RLE encoder package
// Shared widths, register indexes, and the command/status bundles that pass
// between the controller and the datapath.
// ============================================================================
`default_nettype none

package trle_pkg;

    localparam int RUN_MAX_DEF = 60;

    localparam int PIX_W      = 8;
    localparam int CNT_W      = 8;
    localparam int DIM_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 2'd2;

    localparam logic [PIX_W-1:0] TRANSP_RST = 8'd0;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd16;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd16;

    // Source of the byte loaded into the output register.
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_CC,
        SRC_SC,
        SRC_LIT
    } t_src;

    typedef struct packed {
        logic accept;
        logic apply;
        logic emit;
        t_src src;
        logic last;
        logic done;
        logic clear_run;
        logic advance;
        logic lit_start;
        logic lit_next;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic in_solid;
        logic cc_full;
        logic cc_nonzero;
        logic sc_full;
        logic row_end;
        logic last_row;
        logic out_free;
        logic lit_last;
    } t_status;

    // A block dimension of zero behaves as one.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = (v == '0) ? DIM_W'(1) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/trle_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
`default_nettype none

module trle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 60,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/trle_datapath.sv =====
// ============================================================================
// Transparent-run RLE encoder datapath
// Configuration, run counters, position, opaque literal buffer and the
// output register.
// ============================================================================
`default_nettype none

module trle_datapath #(
    parameter int RUN_MAX = trle_pkg::RUN_MAX_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire trle_pkg::t_cmd                    i_cmd,
    output trle_pkg::t_status                      o_status,
    input  wire logic [trle_pkg::PIX_W-1:0]        i_pixel,
    input  wire logic                              i_cfg_valid,
    input  wire logic [trle_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [trle_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [trle_pkg::PIX_W-1:0]             o_code_byte,
    output logic                                   o_last,
    output logic                                   o_sprite_done
);

    localparam int CNT_W  = trle_pkg::CNT_W;
    localparam int DIM_W  = trle_pkg::DIM_W;
    localparam int PIX_W  = trle_pkg::PIX_W;
    localparam int ADDR_W = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1;
    localparam logic [CNT_W-1:0] RUN_LIM = CNT_W'(RUN_MAX);

    logic [PIX_W-1:0]  r_transp;
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [PIX_W-1:0]  r_pixel;
    logic [CNT_W-1:0]  r_cc;
    logic [CNT_W-1:0]  r_sc;
    logic              r_in_solid;
    logic [DIM_W-1:0]  r_col;
    logic [DIM_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_lit_idx;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_code;
    logic              r_last;
    logic              r_done;

    logic [DIM_W-1:0]  w_width_eff;
    logic [DIM_W-1:0]  w_height_eff;
    logic              w_is_clear;
    logic              w_row_end;
    logic              w_last_row;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [PIX_W-1:0]  w_rd_data;
    logic [PIX_W-1:0]  w_out_byte;
    logic [CNT_W:0]    w_lit_count;

    assign w_width_eff  = trle_pkg::eff_dim(r_width);
    assign w_height_eff = trle_pkg::eff_dim(r_height);
    assign w_is_clear   = (r_pixel == r_transp);
    assign w_row_end    = ({1'b0, r_col} + (DIM_W+1)'(1)) >= {1'b0, w_width_eff};
    assign w_last_row   = ({1'b0, r_row} + (DIM_W+1)'(1)) >= {1'b0, w_height_eff};

    // Number of literals sent once the current one goes out.
    assign w_lit_count = {{(CNT_W+1-ADDR_W){1'b0}}, r_lit_idx} + (CNT_W+1)'(1);

    always_comb begin
        o_status.is_clear   = w_is_clear;
        o_status.in_solid   = r_in_solid;
        o_status.cc_full    = (r_cc >= RUN_LIM);
        o_status.cc_nonzero = (r_cc != '0);
        o_status.sc_full    = (r_sc >= RUN_LIM);
        o_status.row_end    = w_row_end;
        o_status.last_row   = w_last_row;
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.lit_last   = (w_lit_count == {1'b0, r_sc});
    end

    // An opaque pixel goes to the slot after the pending literals.
    assign w_wr_en   = i_cmd.apply && !w_is_clear;
    assign w_wr_addr = r_in_solid ? r_sc[ADDR_W-1:0] : '0;
    assign w_rd_en   = i_cmd.lit_start || i_cmd.lit_next;
    assign w_rd_addr = i_cmd.lit_start ? '0 : r_lit_idx + ADDR_W'(1);

    trle_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RUN_MAX),
        .ADDR_W(ADDR_W)
    ) u_buf (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(r_pixel),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    always_comb begin
        case (i_cmd.src)
            trle_pkg::SRC_ZERO: w_out_byte = '0;
            trle_pkg::SRC_CC:   w_out_byte = r_cc;
            trle_pkg::SRC_SC:   w_out_byte = r_sc;
            trle_pkg::SRC_LIT:  w_out_byte = w_rd_data;
            default:            w_out_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transp    <= trle_pkg::TRANSP_RST;
            r_width     <= trle_pkg::WIDTH_RST;
            r_height    <= trle_pkg::HEIGHT_RST;
            r_cc        <= '0;
            r_sc        <= '0;
            r_in_solid  <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    trle_pkg::CFG_TRANSPARENT: r_transp <= i_cfg_data[PIX_W-1:0];
                    trle_pkg::CFG_WIDTH:       r_width  <= i_cfg_data[DIM_W-1:0];
                    trle_pkg::CFG_HEIGHT:      r_height <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.apply) begin
                if (!r_in_solid) begin
                    if (w_is_clear) begin
                        r_cc <= (r_cc >= RUN_LIM) ? CNT_W'(1) : r_cc + CNT_W'(1);
                    end else begin
                        r_in_solid <= 1'b1;
                        r_sc       <= CNT_W'(1);
                    end
                end else if (w_is_clear) begin
                    r_cc       <= CNT_W'(1);
                    r_sc       <= '0;
                    r_in_solid <= 1'b0;
                end else begin
                    r_sc <= r_sc + CNT_W'(1);
                end
            end

            if (i_cmd.clear_run) begin
                r_cc       <= '0;
                r_sc       <= '0;
                r_in_solid <= 1'b0;
            end

            if (i_cmd.advance) begin
                if (w_row_end) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : r_row + DIM_W'(1);
                end else begin
                    r_col <= r_col + DIM_W'(1);
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pixel <= i_pixel;
        end
        if (i_cmd.lit_start) begin
            r_lit_idx <= '0;
        end else if (i_cmd.lit_next) begin
            r_lit_idx <= r_lit_idx + ADDR_W'(1);
        end
        if (i_cmd.emit) begin
            r_code <= w_out_byte;
            r_last <= i_cmd.last;
            r_done <= i_cmd.done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_code_byte   = r_code;
    assign o_last        = r_last;
    assign o_sprite_done = r_done;

endmodule

`default_nettype wire

// ===== hdl/trle_ctrl.sv =====
// ============================================================================
// Transparent-run RLE encoder controller
// Sequences one pixel: pending flushes, run update, row end, and the beats
// of code bytes that each step produces.
// ============================================================================
`default_nettype none

module trle_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output trle_pkg::t_cmd         o_cmd,
    input  wire trle_pkg::t_status i_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_APPLY,
        S_POST,
        S_PAIR_A,
        S_PAIR_B,
        S_HDR_A,
        S_HDR_B,
        S_LIT,
        S_ZERO_A,
        S_ZERO_B
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state r_ret;
    t_state n_ret;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_PRE;
                end
            end
            S_PRE: begin
                // A full transparent run or an ending opaque run goes out
                // before the new pixel is counted.
                if (!i_status.in_solid && i_status.is_clear && i_status.cc_full) begin
                    n_state = S_PAIR_A;
                    n_ret   = S_APPLY;
                end else if (i_status.in_solid && i_status.is_clear) begin
                    n_state = S_HDR_A;
                    n_ret   = S_APPLY;
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_POST;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_POST;
            end
            S_POST: begin
                if (i_status.in_solid && i_status.sc_full) begin
                    n_state = S_HDR_A;
                    n_ret   = S_POST;
                end else if (i_status.row_end) begin
                    n_ret = S_ZERO_A;
                    if (i_status.in_solid) begin
                        n_state = S_HDR_A;
                    end else if (i_status.cc_nonzero) begin
                        n_state = S_PAIR_A;
                    end else begin
                        n_state = S_ZERO_A;
                    end
                end else begin
                    // Nothing left for this pixel: take the next one now.
                    o_cmd.advance = 1'b1;
                    o_in_ready    = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.accept = 1'b1;
                        n_state      = S_PRE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PAIR_A: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = trle_pkg::SRC_CC;
                    n_state    = S_PAIR_B;
                end
            end
            S_PAIR_B: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = trle_pkg::SRC_ZERO;
                    o_cmd.last = !i_status.row_end;
                    n_state    = r_ret;
                end
            end
            S_HDR_A: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = trle_pkg::SRC_CC;
                    n_state    = S_HDR_B;
                end
            end
            S_HDR_B: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.src       = trle_pkg::SRC_SC;
                    o_cmd.lit_start = 1'b1;
                    n_state         = S_LIT;
                end
            end
            S_LIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = trle_pkg::SRC_LIT;
                    if (i_status.lit_last) begin
                        o_cmd.last      = !i_status.row_end;
                        o_cmd.clear_run = 1'b1;
                        n_state         = r_ret;
                    end else begin
                        o_cmd.lit_next = 1'b1;
                    end
                end
            end
            S_ZERO_A: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = trle_pkg::SRC_ZERO;
                    n_state    = S_ZERO_B;
                end
            end
            S_ZERO_B: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.src       = trle_pkg::SRC_ZERO;
                    o_cmd.last      = 1'b1;
                    o_cmd.done      = i_status.last_row;
                    o_cmd.clear_run = 1'b1;
                    o_cmd.advance   = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/transparent_run_rle_encoder.sv =====
// A pixel that produces no code bytes passes the pre-check and the run update,
// and the post-update step already takes the next pixel. A pixel that produces
// bytes also sends each code byte through the single output register, which
// moves one beat a cycle while the receiver is ready. Reset is synchronous:
// counters, position and configuration registers return to their defaults;
// the literal buffer is not cleared.
// ============================================================================
// Transparent-run RLE encoder
// Encodes sprite pixels into transparent-count / opaque-count / literal
// code bytes, row by row, with a 0,0 pair closing each row.
// ============================================================================
`default_nettype none

module transparent_run_rle_encoder #(
    parameter int RUN_MAX = trle_pkg::RUN_MAX_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [trle_pkg::PIX_W-1:0]        i_pixel,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [trle_pkg::PIX_W-1:0]             o_code_byte,
    output logic                                   o_last,
    output logic                                   o_sprite_done,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [trle_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [trle_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    trle_pkg::t_cmd    w_cmd;
    trle_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    trle_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .o_cmd     (w_cmd),
        .i_status  (w_status)
    );

    trle_datapath #(
        .RUN_MAX(RUN_MAX)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_pixel      (i_pixel),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_code_byte  (o_code_byte),
        .o_last       (o_last),
        .o_sprite_done(o_sprite_done)
    );

    // The end of a sprite is always the final byte of its pixel.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sprite_done |-> o_last)
        else $error("sprite_done without last");

    // A full opaque run is flushed before the next pixel is taken.
    a_no_full_run_at_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(w_status.in_solid && w_status.sc_full))
        else $error("pixel accepted with a full opaque run pending");

    // In the cycle after a pixel is taken, the block does not take another one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second pixel accepted in the cycle after a beat");

    // Code bytes are only loaded when the output register can take them.
    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.out_free)
        else $error("code byte overwrote an unsent beat");

endmodule

`default_nettype wire

// ===== tb/transparent_run_rle_encoder_test.sv =====
// ============================================================================
// Transparent-run RLE encoder testbench
// Streams sprite pixels into the encoder under random bursts and receiver
// stalls, predicts every code byte with a behavioral encoder kept in step
// with each accepted beat, and checks byte, last and sprite_done in order.
// ============================================================================
module transparent_run_rle_encoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_MAX     = trle_pkg::RUN_MAX_DEF;
    localparam int PIX_W       = trle_pkg::PIX_W;
    localparam int DIM_W       = trle_pkg::DIM_W;
    localparam int CFG_IDX_W   = trle_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = trle_pkg::CFG_DATA_W;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int IDLE_SETTLE = 16;
    localparam int HOLD_CYCLES = 300;

    // Index past the end of the register list; the block must ignore it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] code;
        logic             last;
        logic             done;
    } t_code_beat;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic [PIX_W-1:0]      i_pixel       = '0;
    logic                  i_out_ready   = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [PIX_W-1:0]      o_code_byte;
    logic                  o_last;
    logic                  o_sprite_done;
    logic                  o_cfg_ready;

    transparent_run_rle_encoder #(
        .RUN_MAX(RUN_MAX)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel      (i_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_code_byte  (o_code_byte),
        .o_last       (o_last),
        .o_sprite_done(o_sprite_done),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Register copies and encoder state of the behavioral model.
    logic [PIX_W-1:0] cfg_transparent = trle_pkg::TRANSP_RST;
    logic [DIM_W-1:0] cfg_width       = trle_pkg::WIDTH_RST;
    logic [DIM_W-1:0] cfg_height      = trle_pkg::HEIGHT_RST;
    int               blank_run       = 0;
    int               solid_run       = 0;
    logic [PIX_W-1:0] solid_lits [RUN_MAX];
    bit               in_solid        = 1'b0;
    int               col_pos         = 0;
    int               row_pos         = 0;

    t_code_beat       step_beats [$];
    t_code_beat       pending_codes [$];
    logic [PIX_W-1:0] pixel_stream [$];
    int               error_count = 0;
    int               cycle_count = 0;

    function automatic void add_byte(input int value);
        t_code_beat b;
        b.code = value[PIX_W-1:0];
        b.last = 1'b0;
        b.done = 1'b0;
        step_beats.push_back(b);
    endfunction

    function automatic void flush_solid();
        add_byte(blank_run);
        add_byte(solid_run);
        for (int i = 0; i < solid_run && i < RUN_MAX; i++) begin
            add_byte(int'(solid_lits[i]));
        end
        blank_run = 0;
        solid_run = 0;
        in_solid  = 1'b0;
    endfunction

    // Advances the encoder by one pixel and queues the code bytes it causes.
    function automatic void encode_pixel(input logic [PIX_W-1:0] pix);
        int w;
        int h;
        bit is_clear;
        w = (cfg_width == '0) ? 1 : int'(cfg_width);
        h = (cfg_height == '0) ? 1 : int'(cfg_height);
        is_clear = (pix == cfg_transparent);
        step_beats.delete();

        if (!in_solid) begin
            if (is_clear) begin
                if (blank_run >= RUN_MAX) begin
                    add_byte(blank_run);
                    add_byte(0);
                    blank_run = 0;
                end
                blank_run++;
            end else begin
                in_solid      = 1'b1;
                solid_lits[0] = pix;
                solid_run     = 1;
            end
        end else if (is_clear) begin
            flush_solid();
            blank_run = 1;
        end else begin
            if (solid_run < RUN_MAX) solid_lits[solid_run] = pix;
            solid_run++;
        end

        if (in_solid && solid_run >= RUN_MAX) flush_solid();

        if (col_pos + 1 >= w) begin
            if (in_solid) begin
                flush_solid();
            end else if (blank_run > 0) begin
                add_byte(blank_run);
                add_byte(0);
            end
            blank_run = 0;
            solid_run = 0;
            in_solid  = 1'b0;
            add_byte(0);
            add_byte(0);
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                step_beats[step_beats.size()-1].done = 1'b1;
                row_pos = 0;
            end else begin
                row_pos = (row_pos + 1) & 12'hFFF;
            end
        end else begin
            col_pos = (col_pos + 1) & 12'hFFF;
        end

        if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
        foreach (step_beats[i]) pending_codes.push_back(step_beats[i]);
    endfunction

    // Pixel driver: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) encode_pixel(i_pixel);
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pixel_stream.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_pixel    <= pixel_stream.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Code byte monitor and receiver stall pattern.
    int beats_seen   = 0;
    int next_hold_at = 200;
    int hold_left    = 0;
    int stall_mode   = 0;
    int mode_left    = 0;
    int pattern_cnt  = 0;

    always @(posedge i_clk) begin
        t_code_beat want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                beats_seen++;
                if (pending_codes.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected code beat: expected none, %s %02h last %0b done %0b",
                             $time, "got byte", o_code_byte, o_last, o_sprite_done);
                end else begin
                    want = pending_codes.pop_front();
                    if (o_code_byte !== want.code || o_last !== want.last ||
                        o_sprite_done !== want.done) begin
                        error_count++;
                        $display("%0t: code mismatch: expected byte %02h last %0b done %0b,",
                                 $time, want.code, want.last, want.done);
                        $display("%0t:     got byte %02h last %0b done %0b",
                                 $time, o_code_byte, o_last, o_sprite_done);
                    end
                end
            end

            // A long hold lets the output back up until the input stalls.
            if (hold_left == 0 && beats_seen >= next_hold_at && pixel_stream.size() > 0) begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + 900;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 120);
            end else begin
                mode_left--;
            end
            pattern_cnt++;

            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 7) != 0);
                    default: i_out_ready <= pattern_cnt[1] ^ pattern_cnt[3];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("transparent_run_rle_encoder verification failed");
            $finish;
        end
    end

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            trle_pkg::CFG_TRANSPARENT: cfg_transparent = data[PIX_W-1:0];
            trle_pkg::CFG_WIDTH:       cfg_width       = data[DIM_W-1:0];
            trle_pkg::CFG_HEIGHT:      cfg_height      = data[DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_dims(input logic [PIX_W-1:0] tc, input int w, input int h);
        write_reg(trle_pkg::CFG_TRANSPARENT, {4'($urandom), tc});
        write_reg(trle_pkg::CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(trle_pkg::CFG_HEIGHT, CFG_DATA_W'(h));
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until the block has drained, then lets it settle.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pixel_stream.size() != 0 || i_in_valid || pending_codes.size() != 0);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // Queues runs of transparent and opaque pixels, some long enough to fill.
    task automatic queue_runs(input int n);
        int len;
        bit clear_run;
        logic [PIX_W-1:0] p;
        while (n > 0) begin
            clear_run = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0, 1: len = $urandom_range(55, 130);
                2:    len = $urandom_range(20, 60);
                default: len = $urandom_range(1, 8);
            endcase
            if (len > n) len = n;
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    p = PIX_W'($urandom_range(0, 255));
                end else if (clear_run) begin
                    p = cfg_transparent;
                end else begin
                    p = PIX_W'($urandom_range(0, 255));
                    if (p == cfg_transparent) p = ~p;
                end
                pixel_stream.push_back(p);
            end
            n = n - len;
        end
    endtask

    initial begin
        logic [PIX_W-1:0] tc;
        int w;
        int h;
        int n;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One full row under reset settings: mixed runs, extreme values.
        pixel_stream = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00,
                         8'hFF, 8'h00, 8'h00, 8'h00, 8'h07, 8'h07, 8'h07, 8'h00};
        wait_idle();

        // Zero width and height act as one; an out-of-range index is ignored.
        write_reg(trle_pkg::CFG_TRANSPARENT, 12'hFFF);
        write_reg(trle_pkg::CFG_WIDTH, 12'd0);
        write_reg(trle_pkg::CFG_HEIGHT, 12'd0);
        write_reg(CFG_UNUSED, 12'hA5A);
        i_cfg_valid <= 1'b0;
        pixel_stream = '{8'hFF, 8'h00, 8'hFF, 8'h55, 8'h80};
        wait_idle();

        for (int ph = 0; ph < 9; ph++) begin
            case ($urandom_range(0, 3))
                0: tc = 8'h00;
                1: tc = 8'hFF;
                default: tc = PIX_W'($urandom_range(0, 255));
            endcase
            case (ph)
                0: begin w = 60;   h = 2;    n = 70; end
                1: begin w = 4095; h = 4095; n = 60; end
                // The column left by the wide phase ends a row at once.
                2: begin w = 7;    h = 4095; n = 60; end
                3: begin w = 120;  h = 1;    n = 80; end
                default: begin
                    case ($urandom_range(0, 6))
                        0: w = 1;
                        1: w = 2;
                        2: w = $urandom_range(3, 16);
                        3: w = 60;
                        4: w = 61;
                        5: w = $urandom_range(62, 130);
                        default: w = $urandom_range(17, 59);
                    endcase
                    case ($urandom_range(0, 3))
                        0: h = 0;
                        1: h = 1;
                        default: h = $urandom_range(2, 6);
                    endcase
                    n = 50;
                end
            endcase
            write_dims(tc, w, h);
            queue_runs(n);
            wait_idle();
        end

        if (error_count == 0) begin
            $display("transparent_run_rle_encoder verification clean");
        end else begin
            $display("transparent_run_rle_encoder verification failed");
        end
        $finish;
    end

endmodule
